// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define CFM_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define CFM_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- hdl/cfm_pkg.sv -----
`default_nettype none
package cfm_pkg;

   // element format
   localparam int DATA_W = 16;
   localparam int FRAC_W = 9;

   // order register
   localparam int ORDER_W = 7;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 7'd64;

   // width of the scaled operand (element magnitude shifted by the fraction bits)
   localparam int WIDE_W = 25;
   localparam int DIV_STEPS = 25;
   localparam int SQRT_STEPS = 13;

   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_FACTOR = 2'd1,
      ACT_READ   = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_INIT,
      ST_LOAD,
      ST_RD,
      ST_MUL,
      ST_ACC,
      ST_CALC,
      ST_WAIT,
      ST_WB
   } state_type;

endpackage
`default_nettype wire

// ----- hdl/cfm_mem.sv -----
`default_nettype none
module cfm_mem import cfm_pkg::*; #(
   parameter int ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [DATA_W-1:0] rd_data_a,
   output logic      [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [1 << ADDR_W];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   // write one element
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read two elements, registered
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

// ----- hdl/cfm_div.sv -----
`default_nettype none
module cfm_div import cfm_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [DATA_W-1:0] num,
   input  wire logic        [DATA_W-1:0] den,
   output logic                          done,
   output logic             [DATA_W-1:0] quo
);

   logic                busy_ff;
   logic                fin_ff;
   logic                done_ff;
   logic [4:0]          cnt_ff;
   logic                neg_ff;
   logic [WIDE_W-1:0]   dvd_ff;
   logic [WIDE_W-1:0]   quo_ff;
   logic [DATA_W-1:0]   rem_ff;
   logic [DATA_W-1:0]   den_ff;
   logic [DATA_W-1:0]   q_ff;

   logic [DATA_W-1:0]   mag;
   logic [DATA_W-1:0]   trial;
   logic                ge;
   logic [WIDE_W:0]     qinc;
   logic [DATA_W-1:0]   q_in;

   // magnitude of the dividend, scaled by the fraction bits on start
   assign mag   = num[DATA_W-1] ? (~num + 16'd1) : num;
   assign trial = {rem_ff[DATA_W-2:0], dvd_ff[WIDE_W-1]};
   assign ge    = (trial >= den_ff);

   // floor and saturate the signed quotient
   always_comb begin
      qinc = {1'b0, quo_ff} + {{WIDE_W{1'b0}}, (rem_ff != '0)};
      if (!neg_ff) begin
         q_in = (quo_ff > 25'd32767) ? 16'h7FFF : quo_ff[DATA_W-1:0];
      end else begin
         q_in = (qinc > 26'd32768) ? 16'h8000 : (~qinc[DATA_W-1:0] + 16'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == 5'(DIV_STEPS - 1))) begin
            busy_ff <= 1'b0;
         end
         fin_ff <= busy_ff && (cnt_ff == 5'(DIV_STEPS - 1));
         if (fin_ff) begin
            done_ff <= 1'b1;
         end
      end
   end

   // one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= num[DATA_W-1];
         dvd_ff <= {mag, {FRAC_W{1'b0}}};
         rem_ff <= '0;
         quo_ff <= '0;
         den_ff <= den;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? (trial - den_ff) : trial;
         quo_ff <= {quo_ff[WIDE_W-2:0], ge};
         dvd_ff <= {dvd_ff[WIDE_W-2:0], 1'b0};
         cnt_ff <= cnt_ff + 5'd1;
      end
      if (fin_ff) begin
         q_ff <= q_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule
`default_nettype wire

// ----- hdl/cfm_sqrt.sv -----
`default_nettype none
module cfm_sqrt import cfm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WIDE_W-1:0] radicand,
   output logic                   done,
   output logic      [DATA_W-1:0] root
);

   logic                busy_ff;
   logic                done_ff;
   logic [3:0]          cnt_ff;
   logic [WIDE_W-1:0]   x_ff;
   logic [WIDE_W-1:0]   r_ff;
   logic [WIDE_W-1:0]   bit_ff;
   logic [DATA_W-1:0]   root_ff;

   logic [WIDE_W-1:0]   sum;
   logic                take;
   logic [WIDE_W-1:0]   r_in;
   logic                last;

   assign sum  = r_ff + bit_ff;
   assign take = (x_ff >= sum);
   assign r_in = take ? ((r_ff >> 1) + bit_ff) : (r_ff >> 1);
   assign last = busy_ff && (cnt_ff == 4'(SQRT_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= last;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // one root bit a cycle
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= radicand;
         r_ff   <= '0;
         bit_ff <= {1'b1, {(WIDE_W-1){1'b0}}};
         cnt_ff <= '0;
      end else if (busy_ff) begin
         if (take) begin
            x_ff <= x_ff - sum;
         end
         r_ff   <= r_in;
         bit_ff <= bit_ff >> 2;
         cnt_ff <= cnt_ff + 4'd1;
      end
      if (last) begin
         root_ff <= r_in[DATA_W-1:0];
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ----- hdl/cholesky_factorization_fixed.sv -----
`default_nettype none
// Channel   Direction  Words
// req_      in         tuser: action; tdata: row, col, value
// rsp_      out        tuser: bad_pivot; tdata: read_value
// csr_      in         order register write
//
// A write element is stored on acceptance; a read element goes through the read state
// (registered memory read). A factorize walks each lower triangle element (i,j): init and
// load, read, multiply and accumulate per product k < j, a calc state, the divider off the
// diagonal or the square root on it, a write back; a non-positive pivot skips the unit.
// Reset is synchronous; the matrix memory is not cleared, only control and the flag.
// A result waits in the output register; a new word is taken once it drains.
`include "assert_macros.svh"
module cholesky_factorization_fixed import cfm_pkg::*; #(
   parameter int MAX_ORDER = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [31:0]         req_tdata,   // row[5:0], col[11:6], value[27:12]
   input  wire logic [1:0]          req_tuser,   // action[1:0]
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic      [DATA_W-1:0]   rsp_tdata,   // read_value[15:0]
   output logic                     rsp_tuser,   // bad_pivot
   input  wire logic                csr_wr_en,
   input  wire logic [ORDER_W-1:0]  csr_wr_data
);

   localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int ADDR_W = 2 * IDX_W;

   state_type state_ff, state_in;

   logic [ORDER_W-1:0]       order_ff;
   logic [IDX_W-1:0]         i_ff, j_ff, k_ff, last_ff;
   logic signed [DATA_W-1:0] acc_ff, piv_ff;
   logic signed [31:0]       prod_ff;
   logic [DATA_W-1:0]        res_ff;
   logic                     flag_ff;
   logic                     read_ok_ff;
   logic                     rsp_tvalid_ff;
   logic [DATA_W-1:0]        rsp_data_ff;
   logic                     rsp_flag_ff;

   action_type               act;
   logic [5:0]               in_row, in_col;
   logic signed [DATA_W-1:0] in_val;
   logic                     in_range;
   logic [IDX_W-1:0]         in_row_idx, in_col_idx;
   logic [31:0]              n_w;
   logic                     accept;
   logic                     diag, fin_elem;

   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_waddr, rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0]        mem_wdata;
   logic signed [DATA_W-1:0] rd_a, rd_b;

   logic                     div_start, div_done, sqrt_start, sqrt_done;
   logic [DATA_W-1:0]        div_q, sqrt_r;

   logic                     rsp_load;
   logic [DATA_W-1:0]        rsp_data_in;
   logic                     rsp_flag_in;

   // unpack the request word
   assign act        = action_type'(req_tuser);
   assign in_row     = req_tdata[5:0];
   assign in_col     = req_tdata[11:6];
   assign in_val     = req_tdata[27:12];
   assign in_range   = (32'(in_row) < 32'(MAX_ORDER)) && (32'(in_col) < 32'(MAX_ORDER));
   assign in_row_idx = IDX_W'(in_row);
   assign in_col_idx = IDX_W'(in_col);
   assign n_w = (32'(order_ff) > 32'(MAX_ORDER)) ? 32'(MAX_ORDER) : 32'(order_ff);

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_tvalid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign diag       = (j_ff == i_ff);
   assign fin_elem   = diag && (i_ff == last_ff);

   cfm_mem #(.ADDR_W(ADDR_W)) u_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   cfm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc_ff),
      .den   (piv_ff),
      .done  (div_done),
      .quo   (div_q)
   );

   cfm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({1'b0, acc_ff[DATA_W-2:0], {FRAC_W{1'b0}}}),
      .done     (sqrt_done),
      .root     (sqrt_r)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (act)
                  ACT_READ:   state_in = ST_READ;
                  ACT_FACTOR: state_in = (n_w != 32'd0) ? ST_INIT : ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_INIT: state_in = ST_LOAD;
         ST_LOAD: state_in = (j_ff == '0) ? ST_CALC : ST_RD;
         ST_RD:   state_in = ST_MUL;
         ST_MUL:  state_in = ST_ACC;
         ST_ACC:  state_in = (k_ff == j_ff - 1'b1) ? ST_CALC : ST_RD;
         ST_CALC: state_in = (div_start || sqrt_start) ? ST_WAIT : ST_WB;
         ST_WAIT: state_in = (div_done || sqrt_done) ? ST_WB : ST_WAIT;
         ST_WB:   state_in = fin_elem ? ST_IDLE : ST_INIT;
         default: state_in = ST_IDLE;
      endcase
   end

   // memory ports, unit starts and result load
   always_comb begin
      mem_we      = 1'b0;
      mem_waddr   = {i_ff, j_ff};
      mem_wdata   = res_ff;
      rd_addr_a   = {in_row_idx, in_col_idx};
      rd_addr_b   = {j_ff, j_ff};
      div_start   = 1'b0;
      sqrt_start  = 1'b0;
      rsp_load    = 1'b0;
      rsp_data_in = '0;
      rsp_flag_in = flag_ff;
      case (state_ff)
         ST_IDLE: begin
            mem_waddr = {in_row_idx, in_col_idx};
            mem_wdata = in_val;
            if (accept) begin
               case (act)
                  ACT_WRITE: begin
                     mem_we   = in_range;
                     rsp_load = 1'b1;
                  end
                  ACT_FACTOR: begin
                     rsp_load    = (n_w == 32'd0);
                     rsp_flag_in = 1'b0;
                  end
                  ACT_READ: rsp_load = 1'b0;
                  default:  rsp_load = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            rsp_load    = 1'b1;
            rsp_data_in = read_ok_ff ? rd_a : '0;
         end
         ST_INIT: rd_addr_a = {i_ff, j_ff};
         ST_RD: begin
            rd_addr_a = {i_ff, k_ff};
            rd_addr_b = {j_ff, k_ff};
         end
         ST_CALC: begin
            sqrt_start = diag && (acc_ff > 0);
            div_start  = !diag && (piv_ff > 0);
         end
         ST_WB: begin
            mem_we   = 1'b1;
            rsp_load = fin_elem;
         end
         default: mem_we = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         order_ff      <= ORDER_RESET;
         flag_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         // clear on factorize start, set on a non-positive pivot
         if (state_ff == ST_IDLE && accept && act == ACT_FACTOR) begin
            flag_ff <= 1'b0;
         end else if (state_ff == ST_CALC &&
                      ((diag && acc_ff <= 0) || (!diag && piv_ff <= 0))) begin
            flag_ff <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_flag_ff <= rsp_flag_in;
      end
      case (state_ff)
         ST_IDLE: begin
            read_ok_ff <= in_range;
            i_ff       <= '0;
            j_ff       <= '0;
            last_ff    <= IDX_W'(n_w - 32'd1);
         end
         ST_LOAD: begin
            acc_ff <= rd_a;
            piv_ff <= rd_b;
            k_ff   <= '0;
         end
         ST_MUL: prod_ff <= rd_a * rd_b;
         ST_ACC: begin
            // subtract the product rounded up to the fraction grid, wrap
            acc_ff <= acc_ff - DATA_W'((prod_ff + 32'sd511) >>> FRAC_W);
            k_ff   <= k_ff + 1'b1;
         end
         ST_CALC: begin
            if (diag) begin
               res_ff <= '0;
            end else begin
               res_ff <= acc_ff[DATA_W-1] ? 16'h8000 : 16'h7FFF;
            end
         end
         ST_WAIT: begin
            if (div_done) begin
               res_ff <= div_q;
            end else if (sqrt_done) begin
               res_ff <= sqrt_r;
            end
         end
         ST_WB: begin
            if (diag) begin
               i_ff <= i_ff + 1'b1;
               j_ff <= '0;
            end else begin
               j_ff <= j_ff + 1'b1;
            end
         end
         default: k_ff <= k_ff;
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flag_ff;

   `CFM_ASSERT(a_mac_index, clock, reset, (state_ff == ST_RD) |-> (k_ff < j_ff), "k past j")
   `CFM_ASSERT(a_lower_tri, clock, reset, (state_ff == ST_INIT) |-> (j_ff <= i_ff && i_ff <= last_ff), "element outside lower triangle")
   `CFM_NEVER(a_rsp_overrun, clock, reset, rsp_load && rsp_tvalid_ff && !rsp_tready, "result overwritten")

endmodule
`default_nettype wire
